// ----- design/pid_controller_with_anti_windup_defines.svh -----
// ----------------------------------------------------------------------------
// pid_controller_with_anti_windup_defines.svh
// Assertion macros used by the PID controller design file.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_WITH_ANTI_WINDUP_DEFINES_SVH
`define PID_CONTROLLER_WITH_ANTI_WINDUP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Antecedent and consequent checked at the same clock edge.
`define PIDAW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent checked at the clock edge after the antecedent.
`define PIDAW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define PIDAW_ASSERT_SAME(label, ante, cons)
`define PIDAW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/pidaw_pkg.sv -----
// ----------------------------------------------------------------------------
// pidaw_pkg
// Types, register map and arithmetic helpers of the PID controller.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int GAIN_W   = 20;
    localparam int LIMIT_W  = 23;
    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int ACC_W    = 32;
    localparam int DRIVE_W  = 24;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST      = 20'd10240;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST     = 20'd0;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST     = 20'd0;
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 23'd1000;
    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST   = 23'd5000;

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4
    } reg_idx_t;

    // Saturate a 33-bit signed sum to the signed 32-bit accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1]) begin
            r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/pid_controller_with_anti_windup.sv -----
// ----------------------------------------------------------------------------
// pid_controller_with_anti_windup
// Fixed-point PID controller with integral clamp anti-windup.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+------------------------------
//  s_       | in        | s_valid / s_ready      | s_setpoint, s_measured (16 s)
//  m_       | out       | m_valid / m_ready      | m_drive (24 s)
//  APB      | in        | psel/penable/pwrite    | paddr (5), pwdata/prdata (32)
//
// One transfer is accepted per cycle while no stall on m_ready holds the
// output register. A sample is held in the input register and is computed
// into the output register when that register can take it; the loop from
// the accumulator through the integral multiplier and clamp sets the cycle.
// Reset is synchronous and active low; it clears the accumulator, the kept
// error and both valid flags, and loads the register defaults.
// A stall on m_ready holds the output register; the input register still
// takes a transfer while it is empty, after which s_ready falls.
//
module pid_controller_with_anti_windup (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Sample input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pidaw_pkg::SAMPLE_W-1:0] s_setpoint,
    input  logic signed [pidaw_pkg::SAMPLE_W-1:0] s_measured,
    // Drive output channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pidaw_pkg::DRIVE_W-1:0] m_drive,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pidaw_pkg::ADDR_W-1:0]         paddr,
    input  logic [pidaw_pkg::DATA_W-1:0]         pwdata,
    output logic [pidaw_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready
);
    import pidaw_pkg::*;

    `include "pid_controller_with_anti_windup_defines.svh"

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [GAIN_W-1:0]  integ_gain_reg;
    logic [GAIN_W-1:0]  deriv_gain_reg;
    logic [LIMIT_W-1:0] integral_limit_reg;
    logic [LIMIT_W-1:0] output_limit_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg      <= PROP_GAIN_RST;
            integ_gain_reg     <= INTEG_GAIN_RST;
            deriv_gain_reg     <= DERIV_GAIN_RST;
            integral_limit_reg <= INTEGRAL_LIMIT_RST;
            output_limit_reg   <= OUTPUT_LIMIT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PROP_GAIN:      prop_gain_reg      <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:     integ_gain_reg     <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:     deriv_gain_reg     <= pwdata[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: integral_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_OUTPUT_LIMIT:   output_limit_reg   <= pwdata[LIMIT_W-1:0];
                default: begin
                    // Addresses past the register list are ignored.
                end
            endcase
        end
    end

    // Read data is combinational; unmapped addresses read as zero.
    always_comb begin
        case (cfg_idx)
            REG_PROP_GAIN:      prdata = {{(DATA_W-GAIN_W){1'b0}}, prop_gain_reg};
            REG_INTEG_GAIN:     prdata = {{(DATA_W-GAIN_W){1'b0}}, integ_gain_reg};
            REG_DERIV_GAIN:     prdata = {{(DATA_W-GAIN_W){1'b0}}, deriv_gain_reg};
            REG_INTEGRAL_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, integral_limit_reg};
            REG_OUTPUT_LIMIT:   prdata = {{(DATA_W-LIMIT_W){1'b0}}, output_limit_reg};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeding the output register
    // ------------------------------------------------------------------
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] setpoint_reg;
    logic signed [SAMPLE_W-1:0] measured_reg;
    logic                       out_valid_reg;
    logic signed [DRIVE_W-1:0]  drive_reg;
    logic                       advance;   // output register can take a result
    logic                       fire;      // a sample is computed this cycle

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_drive = drive_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            setpoint_reg <= s_setpoint;
            measured_reg <= s_measured;
        end
    end

    // ------------------------------------------------------------------
    // Control law
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]  error_sum_reg;
    logic signed [ACC_W-1:0]  error_sum_next;
    logic signed [ERR_W-1:0]  prev_error_reg;

    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W:0]    err_delta;
    logic signed [ACC_W-1:0]  acc_add;
    logic signed [ACC_W-1:0]  acc_sub;
    logic signed [37:0]       p_prod;
    logic signed [52:0]       i_prod;
    logic signed [38:0]       d_prod;
    logic signed [29:0]       p_term;
    logic signed [44:0]       i_term;
    logic signed [30:0]       d_term;
    logic signed [44:0]       ilim_s;
    logic                     i_hi;
    logic                     i_lo;
    logic signed [DRIVE_W-1:0] i_clamped;
    logic signed [31:0]       total;
    logic signed [31:0]       olim_s;
    logic signed [DRIVE_W-1:0] drive_next;

    always_comb begin
        err       = ERR_W'(setpoint_reg) - ERR_W'(measured_reg);
        err_delta = (ERR_W+1)'(err) - (ERR_W+1)'(prev_error_reg);

        // The accumulator only adds the error while the integral gain is nonzero.
        acc_add = (integ_gain_reg != '0)
                ? sat_acc((ACC_W+1)'(error_sum_reg) + (ACC_W+1)'(err))
                : error_sum_reg;

        p_prod = $signed({1'b0, prop_gain_reg}) * err;
        i_prod = $signed({1'b0, integ_gain_reg}) * acc_add;
        d_prod = $signed({1'b0, deriv_gain_reg}) * err_delta;

        // Dropping the low eight bits is a flooring arithmetic shift.
        p_term = p_prod[37:8];
        i_term = i_prod[52:8];
        d_term = d_prod[38:8];

        // Anti-windup: reaching either limit backs this error out again,
        // which also happens with a zero gain when the limit is zero.
        ilim_s  = $signed({22'd0, integral_limit_reg});
        i_hi    = (i_term >= ilim_s);
        i_lo    = (i_term <= -ilim_s);
        acc_sub = sat_acc((ACC_W+1)'(acc_add) - (ACC_W+1)'(err));

        if (i_hi) begin
            i_clamped      = $signed({1'b0, integral_limit_reg});
            error_sum_next = acc_sub;
        end else if (i_lo) begin
            i_clamped      = -$signed({1'b0, integral_limit_reg});
            error_sum_next = acc_sub;
        end else begin
            // Strictly inside the limit, so the term fits the drive width.
            i_clamped      = i_term[DRIVE_W-1:0];
            error_sum_next = acc_add;
        end

        total  = 32'(p_term) + 32'(i_clamped) + 32'(d_term);
        olim_s = $signed({9'd0, output_limit_reg});
        if (total >= olim_s) begin
            drive_next = olim_s[DRIVE_W-1:0];
        end else if (total <= -olim_s) begin
            drive_next = DRIVE_W'(-olim_s);
        end else begin
            drive_next = total[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
        end else if (fire) begin
            error_sum_reg  <= error_sum_next;
            prev_error_reg <= err;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            drive_reg <= drive_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PIDAW_ASSERT_NEXT(a_fire_fills_output, fire, out_valid_reg)
    `PIDAW_ASSERT_NEXT(a_state_holds_when_idle, !fire,
        $stable(error_sum_reg) && $stable(prev_error_reg))
    `PIDAW_ASSERT_SAME(a_backpressure, in_valid_reg && out_valid_reg && !m_ready, !s_ready)
    `PIDAW_ASSERT_SAME(a_drive_symmetric, m_valid, m_drive != {1'b1, {(DRIVE_W-1){1'b0}}})

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the fixed-point PID controller with integral
// clamp anti-windup. A behavioral model of the control law predicts every
// drive value from the accepted samples and the register settings. A checker
// compares each drive transfer with the oldest prediction. Directed tests
// cover the limits and the anti-windup corner cases. A random sweep then runs
// through many register settings, with both channels idling and stalling at
// random in all but the last two phases.
// ----------------------------------------------------------------------------
module tb_top;

    import pidaw_pkg::*;

    // Register indexes past the end of the map; writes there must be ignored.
    localparam logic [2:0] FIRST_SPARE_IDX = 3'd5;
    localparam logic [2:0] LAST_SPARE_IDX  = 3'd7;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -(longint'(1) <<< (ACC_W - 1));

    // Cycles without any transfer before the run is declared hung. The longest
    // legal quiet stretch is a stall burst, a sender gap or a drain hold-off.
    localparam int WATCHDOG_LIMIT = 2000;

    // Margin after the last predicted drive has come out, before a register
    // write or the end of the run.
    localparam int DRAIN_HOLDOFF = 4;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_setpoint;
    logic signed [SAMPLE_W-1:0] s_measured;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [DRIVE_W-1:0]  m_drive;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    pid_controller_with_anti_windup u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_setpoint (s_setpoint),
        .s_measured (s_measured),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // Model state. The register copies are updated when an APB write lands,
    // and the accumulator and kept error advance once per accepted sample.
    // ------------------------------------------------------------------------
    logic [GAIN_W-1:0]  kp_cfg   = PROP_GAIN_RST;
    logic [GAIN_W-1:0]  ki_cfg   = INTEG_GAIN_RST;
    logic [GAIN_W-1:0]  kd_cfg   = DERIV_GAIN_RST;
    logic [LIMIT_W-1:0] ilim_cfg = INTEGRAL_LIMIT_RST;
    logic [LIMIT_W-1:0] olim_cfg = OUTPUT_LIMIT_RST;
    longint             integ_acc    = 0;
    longint             kept_error   = 0;

    // Drive values predicted for samples that were accepted but whose result
    // has not been seen yet, oldest first.
    logic signed [DRIVE_W-1:0] pending_drive[$];

    int fault_cnt    = 0;
    int quiet_cycles = 0;

    // Idle control shared by the sample sender and the drive stall generator.
    bit idle_on   = 1'b1;
    int gap_pct   = 30;
    int stall_pct = 30;

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Control law.
    // ------------------------------------------------------------------------
    function automatic longint clip_acc(input longint v);
        if (v > ACC_MAX) begin
            return ACC_MAX;
        end
        if (v < ACC_MIN) begin
            return ACC_MIN;
        end
        return v;
    endfunction

    // Advances the model by one sample and returns the drive it produces.
    // Products are floored by the arithmetic shift, as in the hardware.
    function automatic logic signed [DRIVE_W-1:0] pid_drive_step(
        input logic signed [SAMPLE_W-1:0] setpoint,
        input logic signed [SAMPLE_W-1:0] measured
    );
        longint err;
        longint p_term;
        longint i_term;
        longint d_term;
        longint total;
        longint ilim;
        longint olim;
        err  = longint'(setpoint) - longint'(measured);
        ilim = longint'(ilim_cfg);
        olim = longint'(olim_cfg);

        // A zero integral gain freezes accumulation, but the clamp below can
        // still take the error back out when the integral limit is zero.
        if (ki_cfg != '0) begin
            integ_acc = clip_acc(integ_acc + err);
        end

        p_term = (longint'(kp_cfg) * err) >>> 8;
        i_term = (longint'(ki_cfg) * integ_acc) >>> 8;
        d_term = (longint'(kd_cfg) * (err - kept_error)) >>> 8;

        // Anti-windup: touching the limit counts as reaching it.
        if (i_term >= ilim) begin
            integ_acc = clip_acc(integ_acc - err);
            i_term    = ilim;
        end else if (i_term <= -ilim) begin
            integ_acc = clip_acc(integ_acc - err);
            i_term    = -ilim;
        end

        total = p_term + i_term + d_term;
        if (total >= olim) begin
            total = olim;
        end else if (total <= -olim) begin
            total = -olim;
        end

        kept_error = err;
        return total[DRIVE_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Drive side: random stall bursts on m_ready. Exactly one assignment is
    // made at each falling edge.
    // ------------------------------------------------------------------------
    initial begin : drive_stall_gen
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b1;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 99) < stall_pct) begin
                    stall_left = $urandom_range(1, 7);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every drive transfer is matched against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_checker
        logic signed [DRIVE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_drive.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10) begin
                    $display("%0t: drive transfer %0d with no sample pending", $time, m_drive);
                end
            end else begin
                want = pending_drive.pop_front();
                if (m_drive !== want) begin
                    fault_cnt++;
                    if (fault_cnt <= 10) begin
                        $display("%0t: m_drive mismatch, expected %0d, got %0d",
                                 $time, want, m_drive);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a run in which nothing moves for too long has hung.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : hang_watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared tasks.
    // ------------------------------------------------------------------------

    // Offers one sample, optionally after a random gap, and waits for the
    // transfer. The prediction is queued at the accepting edge.
    task automatic push_sample(
        input logic signed [SAMPLE_W-1:0] setpoint,
        input logic signed [SAMPLE_W-1:0] measured
    );
        int gap;
        if (idle_on && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 7);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_setpoint <= setpoint;
        s_measured <= measured;
        do @(posedge aclk); while (!s_ready);
        pending_drive.push_back(pid_drive_step(setpoint, measured));
    endtask

    // Stops sending and waits until every predicted drive has come out, then
    // lets the pipeline settle.
    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge aclk);
        repeat (DRAIN_HOLDOFF) @(posedge aclk);
    endtask

    // One APB write: setup cycle, then access cycle until pready. Writes are
    // only issued while the block is drained.
    task automatic apb_write(input logic [2:0] index, input logic [DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_PROP_GAIN:      kp_cfg   = value[GAIN_W-1:0];
            REG_INTEG_GAIN:     ki_cfg   = value[GAIN_W-1:0];
            REG_DERIV_GAIN:     kd_cfg   = value[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: ilim_cfg = value[LIMIT_W-1:0];
            REG_OUTPUT_LIMIT:   olim_cfg = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Loads all five registers after draining the block.
    task automatic load_gains(
        input logic [DATA_W-1:0] kp,
        input logic [DATA_W-1:0] ki,
        input logic [DATA_W-1:0] kd,
        input logic [DATA_W-1:0] ilim,
        input logic [DATA_W-1:0] olim
    );
        hold_until_drained();
        apb_write(REG_PROP_GAIN, kp);
        apb_write(REG_INTEG_GAIN, ki);
        apb_write(REG_DERIV_GAIN, kd);
        apb_write(REG_INTEGRAL_LIMIT, ilim);
        apb_write(REG_OUTPUT_LIMIT, olim);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset defaults: proportional gain of 40 and an output limit of 5000.
    // The full-scale errors saturate the output, and 125 units of error land
    // exactly on the limit.
    task automatic test_reset_defaults();
        push_sample(SAMPLE_MAX, SAMPLE_MIN);
        push_sample(SAMPLE_MIN, SAMPLE_MAX);
        push_sample(16'sd0, 16'sd0);
        push_sample(16'sd1, 16'sd0);
        push_sample(16'sd0, 16'sd1);
        push_sample(16'sd125, 16'sd0);
        push_sample(-16'sd125, 16'sd0);
        push_sample(16'sd3, -16'sd2);
    endtask

    // Unity integral gain with a limit of 1000. The sequence winds up past the
    // limit on both sides and then lands exactly on it on both sides, so the
    // take-back and the equal-to-limit comparisons are all exercised. The
    // output limit equals the integral limit to hit the output clamp exactly.
    task automatic test_integral_clamp();
        load_gains(32'd0, 32'd256, 32'd0, 32'd1000, 32'd1000);
        repeat (4) push_sample(16'sd300, 16'sd0);
        push_sample(16'sd0, 16'sd1000);
        push_sample(16'sd0, 16'sd1000);
        push_sample(-16'sd400, 16'sd500);
        push_sample(16'sd1100, 16'sd0);
    endtask

    // Frozen accumulation with a zero integral limit: the clamp still fires
    // and moves the accumulator by minus the error. Opening the integral path
    // afterwards with a zero error exposes the accumulator on the drive.
    task automatic test_frozen_clamp();
        load_gains(32'd256, 32'd0, 32'd0, 32'd0, 32'h007F_FFFF);
        push_sample(16'sd1000, 16'sd0);
        push_sample(-16'sd1000, 16'sd2000);
        push_sample(SAMPLE_MAX, 16'sd0);
        load_gains(32'd0, 32'd256, 32'd0, 32'h007F_FFFF, 32'h007F_FFFF);
        push_sample(16'sd0, 16'sd0);
    endtask

    // Largest derivative gain with full-scale error steps in both directions.
    task automatic test_derivative_steps();
        load_gains(32'd0, 32'd0, 32'h000F_FFFF, 32'd1000, 32'h007F_FFFF);
        push_sample(SAMPLE_MAX, SAMPLE_MIN);
        push_sample(SAMPLE_MIN, SAMPLE_MAX);
        push_sample(16'sd0, 16'sd0);
        push_sample(16'sd100, 16'sd0);
    endtask

    // Register value for the random sweep: the first phase uses every
    // register at its maximum, the second at zero, the rest mix zero, all
    // ones, small values and full random words (masked by the block).
    function automatic logic [DATA_W-1:0] pick_reg_value(input int phase);
        if (phase == 0) begin
            return '1;
        end
        if (phase == 1) begin
            return '0;
        end
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 1024);
            default: return $urandom();
        endcase
    endfunction

    // Random sweep over register settings. Half the samples use small errors
    // so the integral path stays inside its limits for a while; the other
    // half are full-range. The last phases run without idling.
    task automatic test_random_sweep();
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [SAMPLE_W-1:0] measured;
        longint                     near;
        int                         drain_at;
        for (int phase = 0; phase < 8; phase++) begin
            load_gains(pick_reg_value(phase), pick_reg_value(phase), pick_reg_value(phase),
                       pick_reg_value(phase), pick_reg_value(phase));
            apb_write(FIRST_SPARE_IDX + 3'($urandom_range(0, LAST_SPARE_IDX - FIRST_SPARE_IDX)),
                      $urandom());
            idle_on   = (phase < 6);
            gap_pct   = $urandom_range(10, 60);
            stall_pct = $urandom_range(10, 60);
            drain_at  = $urandom_range(10, 60);
            for (int n = 0; n < 65; n++) begin
                // Pause the sender once per idling phase until the pipe is empty.
                if (idle_on && n == drain_at) begin
                    hold_until_drained();
                end
                setpoint = SAMPLE_W'($urandom());
                if ($urandom_range(0, 1) == 0) begin
                    measured = SAMPLE_W'($urandom());
                end else begin
                    near = longint'(setpoint) - ($urandom_range(0, 64) - 32);
                    if (near > longint'(SAMPLE_MAX)) begin
                        near = longint'(SAMPLE_MAX);
                    end else if (near < longint'(SAMPLE_MIN)) begin
                        near = longint'(SAMPLE_MIN);
                    end
                    measured = near[SAMPLE_W-1:0];
                end
                push_sample(setpoint, measured);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset once, run the tests in turn, drain, and report.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_setpoint = '0;
        s_measured = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_integral_clamp();
        test_frozen_clamp();
        test_derivative_steps();
        test_random_sweep();

        hold_until_drained();
        if (fault_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- pid_controller_with_anti_windup.f -----
+incdir+design
design/pidaw_pkg.sv
design/pid_controller_with_anti_windup.sv
dv/tb_top.sv
